@@ design/hwd_pkg.sv @@
// Package for the Haar wavelet decomposer: constants, defaults and the
// back-end state type. It depends on nothing else.
`default_nettype none

package hwd_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_LEVELS   = 10;
   localparam int DEF_SAMPLE_WIDTH = 16;

   // Level-count register
   localparam int             LEVEL_COUNT_W     = 4;
   localparam logic [LEVEL_COUNT_W-1:0] LEVEL_COUNT_RESET = 4'd10;

   // Fixed point: Q.8 samples, 1/sqrt2 as 46341/65536 with round half up
   localparam int FRAC_BITS     = 8;
   localparam int INV_SQRT2_Q16 = 46341;
   localparam int COEF_W        = 17;
   localparam int SCALE_SHIFT   = 16;
   localparam int ROUND_BIAS    = 32768;

   // Result field widths
   localparam int LEVEL_W = 4;
   localparam int POS_W   = 9;
   localparam int OUT_W   = 32;

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_EVAL,
      BK_OUT
   } back_state_type;

endpackage

`default_nettype wire

@@ design/hwd_queue.sv @@
// Small job queue between the front and back of the Haar decomposer.
// Stand-alone; takes only its width and depth as parameters.
`default_nettype none

module hwd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign rd_data   = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

@@ design/hwd_front.sv @@
// Front end of the Haar decomposer: level-count register, frame counter and
// job creation. Uses hwd_pkg.
`default_nettype none

module hwd_front
   import hwd_pkg::*;
#(
   parameter int MAX_LEVELS   = DEF_MAX_LEVELS,
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  wire logic                          csr_wr_en,
   input  wire logic [LEVEL_COUNT_W-1:0]      csr_level_count,
   input  wire logic                          q_full,
   output logic                               q_push,
   output logic [SAMPLE_WIDTH-1:0]            job_sample,
   output logic [MAX_LEVELS-1:0]              job_index,
   output logic [$clog2(MAX_LEVELS+1)-1:0]    job_levels
);

   localparam int LVL_W = $clog2(MAX_LEVELS + 1);

   logic [LEVEL_COUNT_W-1:0] level_count_ff, level_count_in;
   logic [MAX_LEVELS-1:0]    ctr_ff, ctr_in;
   logic [LVL_W-1:0]         lev_eff;
   logic [MAX_LEVELS-1:0]    frame_mask;
   logic [MAX_LEVELS-1:0]    idx;

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;

   // clamp to 1..MAX_LEVELS
   always_comb begin
      if (level_count_ff == '0) begin
         lev_eff = LVL_W'(1);
      end else if (level_count_ff > MAX_LEVELS) begin
         lev_eff = LVL_W'(MAX_LEVELS);
      end else begin
         lev_eff = LVL_W'(level_count_ff);
      end
   end

   assign frame_mask = ~({MAX_LEVELS{1'b1}} << lev_eff);
   assign idx        = ctr_ff & frame_mask;

   always_comb begin
      level_count_in = csr_wr_en ? csr_level_count : level_count_ff;
      ctr_in         = q_push ? (MAX_LEVELS'(idx + 1'b1) & frame_mask) : ctr_ff;
   end

   assign job_sample = req_sample;
   assign job_index  = idx;
   assign job_levels = lev_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_count_ff <= LEVEL_COUNT_RESET;
         ctr_ff         <= '0;
      end else begin
         level_count_ff <= level_count_in;
         ctr_ff         <= ctr_in;
      end
   end

endmodule

`default_nettype wire

@@ design/hwd_back.sv @@
// Back end of the Haar decomposer: per-level held values, the scaled
// sum/difference datapath and the result register. Uses hwd_pkg.
`default_nettype none

module hwd_back
   import hwd_pkg::*;
#(
   parameter int MAX_LEVELS   = DEF_MAX_LEVELS,
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         job_valid,
   output logic                              job_pop,
   input  wire logic [SAMPLE_WIDTH-1:0]      job_sample,
   input  wire logic [MAX_LEVELS-1:0]        job_index,
   input  wire logic [$clog2(MAX_LEVELS+1)-1:0] job_levels,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [LEVEL_W-1:0]                rsp_level,
   output logic [POS_W-1:0]                  rsp_position,
   output logic signed [OUT_W-1:0]           rsp_average,
   output logic signed [OUT_W-1:0]           rsp_detail,
   output logic                              rsp_run_last,
   output logic                              rsp_frame_done
);

   localparam int LVL_W  = $clog2(MAX_LEVELS + 1);
   localparam int IDX_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   // each level grows by at most sqrt2, plus rounding and sign margin
   localparam int VAL_W  = SAMPLE_WIDTH + FRAC_BITS + (MAX_LEVELS + 1) / 2 + 2;
   localparam int SUM_W  = VAL_W + 1;
   localparam int PROD_W = SUM_W + COEF_W;
   localparam int RND_W  = PROD_W - SCALE_SHIFT;
   localparam int Q8_W   = SAMPLE_WIDTH + FRAC_BITS;

   back_state_type state_ff, state_in;

   logic signed [VAL_W-1:0]  cur_ff, cur_in;
   logic [MAX_LEVELS-1:0]    idx_ff, idx_in;
   logic [LVL_W-1:0]         lev_ff, lev_in;
   logic [LVL_W-1:0]         k_ff, k_in;
   logic signed [PROD_W-1:0] psum_ff, psum_in;
   logic signed [PROD_W-1:0] pdif_ff, pdif_in;
   logic signed [VAL_W-1:0]  held_ff [MAX_LEVELS];
   logic signed [VAL_W-1:0]  held_in;
   logic [IDX_W-1:0]         held_wa;
   logic                     held_we;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]       level_ff;
   logic [POS_W-1:0]         position_ff;
   logic signed [OUT_W-1:0]  average_ff, detail_ff;
   logic                     run_last_ff, frame_done_ff;

   logic [IDX_W-1:0]         k_idx;
   logic [LVL_W-1:0]         k_nxt;
   logic                     at_top, cur_bit, is_last, out_free;
   logic                     eval_finish, mul_en, res_load;
   logic [MAX_LEVELS-1:0]    idx_shift, nxt_shift;
   logic signed [VAL_W-1:0]  held_rd;
   logic signed [SUM_W-1:0]  sum_w, dif_w;
   logic signed [PROD_W-1:0] rsum_full, rdif_full;
   logic signed [RND_W-1:0]  avg_val, det_val;
   logic signed [Q8_W-1:0]   q8;

   // ---- decode of the current level ----
   assign k_idx       = k_ff[IDX_W-1:0];
   assign k_nxt       = k_ff + LVL_W'(1);
   assign at_top      = (k_ff == lev_ff);
   assign idx_shift   = idx_ff >> k_ff;
   assign nxt_shift   = idx_ff >> k_nxt;
   assign cur_bit     = idx_shift[0];
   assign is_last     = (k_nxt == lev_ff) || !nxt_shift[0];
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign eval_finish = at_top || !cur_bit;

   // ---- datapath ----
   assign held_rd = held_ff[k_idx];
   assign sum_w   = SUM_W'(held_rd) + SUM_W'(cur_ff);
   assign dif_w   = SUM_W'(held_rd) - SUM_W'(cur_ff);
   assign psum_in = PROD_W'(sum_w) * PROD_W'(INV_SQRT2_Q16);
   assign pdif_in = PROD_W'(dif_w) * PROD_W'(INV_SQRT2_Q16);

   // round half up: floor((p + 2^15) / 2^16)
   assign rsum_full = (psum_ff + PROD_W'(ROUND_BIAS)) >>> SCALE_SHIFT;
   assign rdif_full = (pdif_ff + PROD_W'(ROUND_BIAS)) >>> SCALE_SHIFT;
   assign avg_val   = $signed(rsum_full[RND_W-1:0]);
   assign det_val   = $signed(rdif_full[RND_W-1:0]);

   assign q8 = $signed({job_sample, {FRAC_BITS{1'b0}}});

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               state_in = BK_EVAL;
            end
         end
         BK_EVAL: begin
            if (eval_finish) begin
               state_in = job_valid ? BK_EVAL : BK_IDLE;
            end else begin
               state_in = BK_OUT;
            end
         end
         BK_OUT: begin
            if (out_free) begin
               if (is_last) begin
                  state_in = job_valid ? BK_EVAL : BK_IDLE;
               end else begin
                  state_in = BK_EVAL;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // ---- control outputs ----
   always_comb begin
      job_pop  = 1'b0;
      mul_en   = 1'b0;
      res_load = 1'b0;
      held_we  = 1'b0;
      held_wa  = k_idx;
      held_in  = cur_ff;
      case (state_ff)
         BK_IDLE: begin
            job_pop = job_valid;
         end
         BK_EVAL: begin
            if (eval_finish) begin
               job_pop = job_valid;
               // even position at this level: hold the value for its partner
               held_we = !at_top;
            end else begin
               mul_en = 1'b1;
            end
         end
         BK_OUT: begin
            if (out_free) begin
               res_load = 1'b1;
               if (is_last) begin
                  job_pop = job_valid;
                  // average lands as the even value of the next level
                  held_we = (k_nxt != lev_ff);
                  held_wa = k_nxt[IDX_W-1:0];
                  held_in = avg_val[VAL_W-1:0];
               end
            end
         end
         default: begin
            job_pop = 1'b0;
         end
      endcase
   end

   // ---- working registers ----
   always_comb begin
      cur_in = cur_ff;
      idx_in = idx_ff;
      lev_in = lev_ff;
      k_in   = k_ff;
      if (job_pop) begin
         cur_in = VAL_W'(q8);
         idx_in = job_index;
         lev_in = job_levels;
         k_in   = '0;
      end else if (res_load && !is_last) begin
         cur_in = avg_val[VAL_W-1:0];
         k_in   = k_nxt;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      lev_ff <= lev_in;
      k_ff   <= k_in;
      if (mul_en) begin
         psum_ff <= psum_in;
         pdif_ff <= pdif_in;
      end
      if (held_we) begin
         held_ff[held_wa] <= held_in;
      end
      if (res_load) begin
         level_ff      <= LEVEL_W'(k_ff);
         position_ff   <= POS_W'(nxt_shift);
         average_ff    <= OUT_W'(avg_val);
         detail_ff     <= OUT_W'(det_val);
         run_last_ff   <= is_last;
         frame_done_ff <= (k_nxt == lev_ff);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_level      = level_ff;
   assign rsp_position   = position_ff;
   assign rsp_average    = average_ff;
   assign rsp_detail     = detail_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_frame_done = frame_done_ff;

endmodule

`default_nettype wire

@@ design/haar_wavelet_decompose.sv @@
// Streaming multilevel Haar decomposer: front end, job queue, back end.
// The back end finishes a sample that gives no result in its evaluate state
// and spends an evaluate step (multiply) and an output step (round into the
// output register) on each result; it takes a new sample only when done with
// the last one, and a 4-deep job queue absorbs bursts.
// Reset (synchronous, active high) clears the counter, queue and handshakes.
`default_nettype none

module haar_wavelet_decompose
   import hwd_pkg::*;
#(
   parameter int MAX_LEVELS   = DEF_MAX_LEVELS,
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // sample channel
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_sample,
   // result channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [LEVEL_W-1:0]                  rsp_level,
   output logic [POS_W-1:0]                    rsp_position,
   output logic signed [OUT_W-1:0]             rsp_average,
   output logic signed [OUT_W-1:0]             rsp_detail,
   output logic                                rsp_run_last,
   output logic                                rsp_frame_done,
   // level-count register
   input  wire logic                           csr_wr_en,
   input  wire logic [LEVEL_COUNT_W-1:0]       csr_level_count
);

   localparam int LVL_W = $clog2(MAX_LEVELS + 1);
   localparam int JOB_W = SAMPLE_WIDTH + MAX_LEVELS + LVL_W;

   // Front-end job: raw sample, its index within the frame, and the
   // clamped level count in force when it was taken.
   logic                    q_push, q_full, q_pop, q_not_empty;
   logic [SAMPLE_WIDTH-1:0] f_sample, b_sample;
   logic [MAX_LEVELS-1:0]   f_index, b_index;
   logic [LVL_W-1:0]        f_levels, b_levels;
   logic [JOB_W-1:0]        q_wr_data, q_rd_data;

   hwd_front #(
      .MAX_LEVELS   (MAX_LEVELS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .csr_wr_en       (csr_wr_en),
      .csr_level_count (csr_level_count),
      .q_full          (q_full),
      .q_push          (q_push),
      .job_sample      (f_sample),
      .job_index       (f_index),
      .job_levels      (f_levels)
   );

   assign q_wr_data = {f_sample, f_index, f_levels};

   // Decouple intake from the per-level work so samples keep flowing while
   // a burst of coarse-level results drains.
   hwd_queue #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wr_data   (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .rd_data   (q_rd_data),
      .not_empty (q_not_empty)
   );

   assign {b_sample, b_index, b_levels} = q_rd_data;

   // Back end walks levels finest first: hold on an even position, otherwise
   // pair with the held value, emit, and carry the average upward.
   hwd_back #(
      .MAX_LEVELS   (MAX_LEVELS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (q_not_empty),
      .job_pop        (q_pop),
      .job_sample     (b_sample),
      .job_index      (b_index),
      .job_levels     (b_levels),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_level      (rsp_level),
      .rsp_position   (rsp_position),
      .rsp_average    (rsp_average),
      .rsp_detail     (rsp_detail),
      .rsp_run_last   (rsp_run_last),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule

`default_nettype wire

@@ design/hwd_checker.sv @@
// Port-level checks for the Haar decomposer, bound to the top level.
// Sees only the result channel ports; uses hwd_pkg for field widths.
`default_nettype none

module hwd_checker
   import hwd_pkg::*;
#(
   parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic [LEVEL_W-1:0]      rsp_level,
   input wire logic [POS_W-1:0]        rsp_position,
   input wire logic signed [OUT_W-1:0] rsp_average,
   input wire logic signed [OUT_W-1:0] rsp_detail,
   input wire logic                    rsp_run_last,
   input wire logic                    rsp_frame_done
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_level)
         && $stable(rsp_position) && $stable(rsp_average) && $stable(rsp_detail)
         && $stable(rsp_run_last) && $stable(rsp_frame_done))
      else $error("result changed while stalled");

   // the coarsest pair always ends its sample's run
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_run_last)
      else $error("frame end without run end");

   // the coarsest level has a single pair
   a_done_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_position == '0)
      else $error("frame end at non-zero position");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_level) < MAX_LEVELS)
      else $error("level out of range");

   // reset drops any pending result
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind haar_wavelet_decompose hwd_checker #(
   .MAX_LEVELS (MAX_LEVELS)
) u_hwd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_level      (rsp_level),
   .rsp_position   (rsp_position),
   .rsp_average    (rsp_average),
   .rsp_detail     (rsp_detail),
   .rsp_run_last   (rsp_run_last),
   .rsp_frame_done (rsp_frame_done)
);

`default_nettype wire
